// File: rtl/extent_map_translate_alloc_unit_macros.svh
// Assertion macros shared by the extent map translation block.
`ifndef EXTENT_MAP_TRANSLATE_ALLOC_UNIT_MACROS_SVH
`define EXTENT_MAP_TRANSLATE_ALLOC_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EMTA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define EMTA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// The condition must hold at every clock edge outside reset.
`define EMTA_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error(msg);

`endif

// File: rtl/emta_pkg.sv
// Types, codes and defaults shared by the extent map translation block.
`timescale 1ns / 1ps
`default_nettype none

package emta_pkg;

  localparam int DEF_MAX_REGIONS = 16;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_BLOCKS = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_SIZE = 8'd1;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_DISK_FULL = 2'd1;
  localparam logic [1:0] ST_TABLE_FULL = 2'd2;

  localparam logic [31:0] RST_TOTAL_BLOCKS = 32'hFFFF_FFFF;
  localparam logic [7:0] RST_REGION_SIZE = 8'd8;
  localparam logic [31:0] RST_NEXT_FREE = 32'd1;

  typedef struct packed {
    logic [31:0] total_blocks;
    logic [7:0]  region_size;
  } cfg_t;

  typedef struct packed {
    logic [31:0] start;
    logic [7:0]  length;
  } region_t;

endpackage

`default_nettype wire

// File: rtl/extent_map_translate_alloc_unit.sv
// Top level: translates logical block indexes through an extent table.
`timescale 1ns / 1ps
`default_nettype none

// Extent map translation with a bump allocator.
// An item is taken at a rising edge with start high and busy low; it carries
// one 32-bit logical_index. Exactly one result follows: done is high for one
// cycle with physical_block and status (0 ok, 1 disk full, 2 table full).
// The receiver cannot stall; the result is simply presented for that cycle.
// The region table sits in a synchronous memory read one entry per cycle.
// For a hit in entry k (counted from 0), done goes high once the walk has
// compared entries 0 to k, and the result is taken at the edge after that. A miss
// walks all used entries and then passes through the allocate decision state, so
// done goes high after that state; with an empty table the walk is skipped.
// The block can take the next item in the cycle in which done is high; the
// longest item is a miss with sixteen regions in use.
// Configuration writes use cfg_valid/cfg_ready with cfg_index and cfg_data;
// ready is always high, and writes belong in idle periods only.
// Reset sets total_blocks to all ones, region_size to 8, the used count to 0
// and the bump pointer to 1. Table entries are left as they are; only entries
// below the used count are ever read, so no clearing pass is needed.
module extent_map_translate_alloc_unit #(
  parameter int MAX_REGIONS = emta_pkg::DEF_MAX_REGIONS
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [31:0]                    logical_index,
  output logic                                done,
  output logic [31:0]                         physical_block,
  output logic [1:0]                          status,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [emta_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [emta_pkg::CFG_DATA_W-1:0] cfg_data
);
  import emta_pkg::*;

  localparam int IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int CNT_W = $clog2(MAX_REGIONS + 1);
  localparam int SUM_W = $clog2(MAX_REGIONS * 255 + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_DECIDE = 2'd2;

  cfg_t cfg;

  logic [1:0]       state;
  logic [31:0]      idx;
  logic [IDX_W-1:0] ptr;
  logic [SUM_W-1:0] sum;
  logic [CNT_W-1:0] regions_used;
  logic [31:0]      next_free_block;

  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  region_t          rd_data;
  logic             wr_en;
  region_t          wr_data;

  logic             accept;
  logic [SUM_W-1:0] upper;
  logic             hit;
  logic             last;
  logic [32:0]      alloc_end;
  logic             table_full;
  logic             no_space;

  emta_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  emta_region_ram #(
    .DEPTH  (MAX_REGIONS),
    .ADDR_W (IDX_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (regions_used[IDX_W-1:0]),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign busy = (state != S_IDLE);
  assign accept = start && !busy;

  assign upper = sum + SUM_W'(rd_data.length);
  assign hit = (idx < 32'(upper));
  assign last = ((CNT_W'(ptr) + 1'b1) == regions_used);

  assign alloc_end = {1'b0, next_free_block} + 33'(cfg.region_size);
  assign table_full = (regions_used == CNT_W'(MAX_REGIONS));
  assign no_space = (alloc_end > {1'b0, cfg.total_blocks});

  // Reads run one entry ahead of the compare, so the walk never waits on the
  // memory. The only write is the allocation, issued after the walk has
  // ended, so a read never meets a write to the same entry in flight.
  always_comb begin
    rd_en = 1'b0;
    rd_addr = ptr + 1'b1;
    if (state == S_IDLE) begin
      rd_en = accept && (regions_used != '0);
      rd_addr = '0;
    end else if (state == S_WALK) begin
      rd_en = !hit && !last;
    end
  end

  assign wr_en = (state == S_DECIDE) && !table_full && !no_space;
  assign wr_data.start = next_free_block;
  assign wr_data.length = cfg.region_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      regions_used <= '0;
      next_free_block <= RST_NEXT_FREE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= (regions_used == '0) ? S_DECIDE : S_WALK;
          end
        end
        S_WALK: begin
          if (hit) begin
            done <= 1'b1;
            state <= S_IDLE;
          end else if (last) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          done <= 1'b1;
          state <= S_IDLE;
          if (wr_en) begin
            regions_used <= regions_used + 1'b1;
            next_free_block <= alloc_end[31:0];
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers: walk position, running sum and the result.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        idx <= logical_index;
        ptr <= '0;
        sum <= '0;
      end
      S_WALK: begin
        ptr <= ptr + 1'b1;
        sum <= upper;
        physical_block <= rd_data.start + (idx - 32'(sum));
        status <= ST_OK;
      end
      S_DECIDE: begin
        if (table_full) begin
          physical_block <= '0;
          status <= ST_TABLE_FULL;
        end else if (no_space) begin
          physical_block <= '0;
          status <= ST_DISK_FULL;
        end else begin
          physical_block <= next_free_block;
          status <= ST_OK;
        end
      end
      default: ;
    endcase
  end

`include "extent_map_translate_alloc_unit_macros.svh"

  `EMTA_ASSERT_NEXT(a_accept_busy, clk, rst, accept, busy, "accepted item did not raise busy")
  `EMTA_ASSERT_SAME(a_fail_zero, clk, rst, done && (status != ST_OK), physical_block == '0,
                    "failed result carries a nonzero block")
  `EMTA_ASSERT_ALWAYS(a_used_bound, clk, rst, regions_used <= CNT_W'(MAX_REGIONS),
                      "region count exceeds table depth")
  `EMTA_ASSERT_SAME(a_write_room, clk, rst, wr_en, !table_full && (state == S_DECIDE),
                    "region write without a free entry")

endmodule

`default_nettype wire

// File: rtl/emta_region_ram.sv
// Region table memory: one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module emta_region_ram #(
  parameter int DEPTH = emta_pkg::DEF_MAX_REGIONS,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire emta_pkg::region_t wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output emta_pkg::region_t      rd_data
);
  import emta_pkg::*;

  region_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/emta_cfg_regs.sv
// Configuration registers: volume block count and new region size.
`timescale 1ns / 1ps
`default_nettype none

module emta_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [emta_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [emta_pkg::CFG_DATA_W-1:0] cfg_data,
  output emta_pkg::cfg_t                      cfg
);
  import emta_pkg::*;

  assign cfg_ready = 1'b1;

  // Writes to indexes past the register list fall through and are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.total_blocks <= RST_TOTAL_BLOCKS;
      cfg.region_size <= RST_REGION_SIZE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TOTAL_BLOCKS: cfg.total_blocks <= cfg_data[31:0];
        REG_REGION_SIZE:  cfg.region_size <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: verif/tb.sv
// Self-checking testbench for the extent map translation block with bump allocation.
`timescale 1ns / 1ps

module tb;
  import emta_pkg::*;

  localparam int MAX_EXTENTS = DEF_MAX_REGIONS;
  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_CYCLES = 2 * MAX_EXTENTS + 4;
  localparam int REPORT_LIMIT = 10;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 8'hFF;

  typedef struct {
    logic [31:0] index;
    logic [31:0] block;
    logic [1:0]  status;
  } translation_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [31:0] logical_index = '0;
  logic done;
  logic [31:0] physical_block;
  logic [1:0] status;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Shadow copy of the block's registers and extent table.
  logic [31:0] cfg_total_blocks = RST_TOTAL_BLOCKS;
  logic [7:0]  cfg_region_size = RST_REGION_SIZE;
  logic [31:0] extent_base [MAX_EXTENTS];
  logic [7:0]  extent_len [MAX_EXTENTS];
  int          regions_in_use = 0;
  logic [31:0] alloc_cursor = RST_NEXT_FREE;
  logic [31:0] mapped_blocks = '0;

  translation_t pending_translations[$];
  translation_t head;

  int sender_idle_pct = 0;
  int mismatch_count = 0;
  int results_checked = 0;
  int hit_count = 0;
  int alloc_count = 0;
  int no_space_count = 0;
  int table_full_count = 0;
  int cycle_count = 0;

  extent_map_translate_alloc_unit dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .logical_index(logical_index),
    .done(done),
    .physical_block(physical_block),
    .status(status),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_translations.size());
      $display("FAIL");
      $finish;
    end
  end

  // Walks the shadow table and allocates on a miss, exactly as the block should.
  function automatic translation_t translate_index(input logic [31:0] idx);
    translation_t r;
    logic [32:0] base;
    logic [32:0] region_end;
    logic found;
    r.index = idx;
    r.block = '0;
    r.status = ST_OK;
    found = 1'b0;
    base = '0;
    for (int k = 0; k < regions_in_use; k++) begin
      if (!found && {1'b0, idx} < base + extent_len[k]) begin
        r.block = extent_base[k] + (idx - base[31:0]);
        found = 1'b1;
        hit_count++;
      end
      base = base + extent_len[k];
    end
    if (!found) begin
      region_end = {1'b0, alloc_cursor} + cfg_region_size;
      if (regions_in_use >= MAX_EXTENTS) begin
        r.status = ST_TABLE_FULL;
        table_full_count++;
      end else if (region_end > {1'b0, cfg_total_blocks}) begin
        r.status = ST_DISK_FULL;
        no_space_count++;
      end else begin
        r.block = alloc_cursor;
        extent_base[regions_in_use] = alloc_cursor;
        extent_len[regions_in_use] = cfg_region_size;
        regions_in_use++;
        alloc_cursor = region_end[31:0];
        mapped_blocks = mapped_blocks + cfg_region_size;
        alloc_count++;
      end
    end
    return r;
  endfunction

  // Mostly indexes inside the mapped range; misses either land just past it or anywhere.
  function automatic logic [31:0] pick_index(input int miss_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (mapped_blocks == 0 || roll < miss_pct) begin
      if ($urandom_range(0, 1) == 1)
        return mapped_blocks + $urandom_range(0, 3);
      return $urandom;
    end
    return $urandom_range(0, mapped_blocks - 1);
  endfunction

  task automatic note_mismatch(input translation_t want, input logic unexpected);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      if (unexpected)
        $display("result with nothing outstanding: block %h status %0d", physical_block, status);
      else
        $display("index %h: expected block %h status %0d, got block %h status %0d",
                 want.index, want.block, want.status, physical_block, status);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && done === 1'b1) begin
      results_checked++;
      if (pending_translations.size() == 0) begin
        note_mismatch(head, 1'b1);
      end else begin
        head = pending_translations.pop_front();
        if (physical_block !== head.block || status !== head.status)
          note_mismatch(head, 1'b0);
      end
    end
  end

  // Start stays high across back-to-back items; here it drops only for an idle gap.
  task automatic send_index(input logic [31:0] idx);
    start <= 1'b1;
    logical_index <= idx;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_translations.push_back(translate_index(idx));
    if (sender_idle_pct > 0 && $urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (pending_translations.size() != 0) @(posedge clk);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data,
                         input logic last);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_TOTAL_BLOCKS: cfg_total_blocks = data;
      REG_REGION_SIZE:  cfg_region_size = data[7:0];
      default: ;
    endcase
    if (last)
      cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] size_word(input int size);
    return ($urandom & 32'hFFFF_FF00) | size;
  endfunction

  task automatic run_random(input int count, input int miss_pct);
    for (int n = 0; n < count; n++)
      send_index(pick_index(miss_pct));
  endtask

  // First allocation on an empty table with an index far past the new region, then hits and a second allocation.
  task automatic test_first_allocations();
    send_index(32'hFFFF_FFFF);
    send_index(32'd0);
    send_index(32'd7);
    send_index(32'd8);
    send_index(32'd15);
  endtask

  // A zero-length region is allocated but never matches afterwards.
  task automatic test_zero_size_region();
    set_reg(REG_REGION_SIZE, size_word(0), 1'b1);
    send_index(32'd16);
  endtask

  // Allocation limits: volume smaller than the bump pointer, then ends exactly at the limit.
  task automatic test_disk_full_bounds();
    set_reg(REG_REGION_SIZE, size_word(255), 1'b0);
    set_reg(REG_TOTAL_BLOCKS, 32'd2, 1'b1);
    send_index(32'd100);
    send_index(32'd16);
    set_reg(REG_TOTAL_BLOCKS, alloc_cursor + 32'd255, 1'b1);
    send_index(32'd16);
    send_index(32'd270);
    send_index(32'd271);
    set_reg(REG_REGION_SIZE, size_word(1), 1'b0);
    set_reg(REG_TOTAL_BLOCKS, alloc_cursor + 32'd1, 1'b1);
    send_index(32'd271);
    send_index(32'hFFFF_FFFF);
  endtask

  // Writes to indexes outside the register map must leave both registers alone.
  task automatic test_unmapped_register();
    set_reg(REG_TOTAL_BLOCKS, RST_TOTAL_BLOCKS, 1'b0);
    set_reg(REG_REGION_SIZE, size_word(8), 1'b0);
    set_reg(REG_UNMAPPED_LO, $urandom, 1'b0);
    set_reg(REG_UNMAPPED_HI, $urandom, 1'b1);
    send_index(32'd0);
    send_index(32'd271);
    send_index(32'd272);
    send_index(32'd275);
  endtask

  task automatic test_random_open_volume();
    sender_idle_pct = 18;
    set_reg(REG_TOTAL_BLOCKS, RST_TOTAL_BLOCKS, 1'b0);
    set_reg(REG_REGION_SIZE, size_word($urandom_range(1, 255)), 1'b1);
    run_random(500, 1);
  endtask

  // A volume limit just above the bump pointer makes most misses come back disk full.
  task automatic test_random_tight_volume();
    sender_idle_pct = 78;
    set_reg(REG_REGION_SIZE, size_word($urandom_range(0, 255)), 1'b0);
    set_reg(REG_TOTAL_BLOCKS, alloc_cursor + $urandom_range(0, 600), 1'b1);
    run_random(500, 4);
  endtask

  task automatic test_table_full();
    sender_idle_pct = 0;
    set_reg(REG_TOTAL_BLOCKS, RST_TOTAL_BLOCKS, 1'b0);
    set_reg(REG_REGION_SIZE, size_word($urandom_range(1, 255)), 1'b1);
    while (regions_in_use < MAX_EXTENTS)
      send_index(mapped_blocks + $urandom_range(0, 7));
    send_index(mapped_blocks);
    send_index(32'hFFFF_FFFF);
    send_index(mapped_blocks - 1);
  endtask

  task automatic test_random_full_table();
    sender_idle_pct = 0;
    run_random(560, 10);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_first_allocations();
    test_zero_size_region();
    test_disk_full_bounds();
    test_unmapped_register();
    test_random_open_volume();
    test_random_tight_volume();
    test_table_full();
    test_random_full_table();
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("translated %0d indexes: %0d hits, %0d allocations, %0d disk full, %0d table full",
             hit_count + alloc_count + no_space_count + table_full_count, hit_count,
             alloc_count, no_space_count, table_full_count);
    $display("compared %0d results, %0d mismatches, %0d regions in use", results_checked,
             mismatch_count, regions_in_use);
    if (mismatch_count == 0 && pending_translations.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
